>>> rtl/core/dpag_pkg.sv
`default_nettype none
package dpag_pkg;
    typedef struct packed {
        logic        operation;
        logic [15:0] pixel;
        logic        in_bounds;
        logic        last;
    } t_in_item;
    typedef struct packed {
        logic        kind;
        logic [7:0]  gray;
        logic [24:0] overload_count;
        logic [31:0] scale_used;
    } t_out_item;
    // classified request passed from front to back
    typedef struct packed {
        logic        is_map;
        logic        last;
        logic        in_bounds;
        logic        is_over;
        logic        is_valid;
        logic [15:0] px;
    } t_work;
    localparam logic        OP_STATS = 1'b0;
    localparam logic        KIND_MAP = 1'b0;
    localparam logic        KIND_SUM = 1'b1;
    localparam logic [1:0]  ADDR_SCALE = 2'd0;
    localparam logic [1:0]  ADDR_NEGATE = 2'd1;
    localparam logic [1:0]  ADDR_SWAP = 2'd2;
    localparam logic [31:0] SCALE_RESET = 32'd53687091;
    localparam logic [56:0] SUMSQ_MAX = {57{1'b1}};
    typedef enum logic [2:0] {
        ST_RUN, ST_DIV, ST_SQRT, ST_OUT
    } t_state;
endpackage
`default_nettype wire

>>> rtl/core/dpag_front.sv
`default_nettype none
module dpag_front #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_swap,
    input  wire logic              i_push,
    input  wire dpag_pkg::t_in_item i_item,
    output logic                   o_full,
    input  wire logic              i_take,
    output logic                   o_has,
    output dpag_pkg::t_work        o_work
);
    localparam int AW = $clog2(DEPTH);
    dpag_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    dpag_pkg::t_work w;
    logic [15:0] px;
    logic do_push, do_take;
    always_comb begin
        px = i_swap ? {i_item.pixel[7:0], i_item.pixel[15:8]} : i_item.pixel;
        w.is_map = i_item.operation != dpag_pkg::OP_STATS;
        w.last = i_item.last;
        w.in_bounds = i_item.in_bounds;
        w.is_over = px == 16'hFFFF;
        w.is_valid = px != 16'h0000 && px != 16'hFFFF;
        w.px = px;
    end
    assign o_full = r_cnt == (AW+1)'(DEPTH);
    assign o_has = r_cnt != '0;
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_has;
    assign o_work = r_mem[r_rp];
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= w;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (do_take) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_take);
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/dpag_back.sv
`default_nettype none
module dpag_back #(
    parameter int MAX_FRAME_PIXELS = 16777216
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [31:0]        i_manual_scale,
    input  wire logic               i_negate,
    input  wire logic               i_has,
    input  wire dpag_pkg::t_work    i_work,
    output logic                    o_take,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output dpag_pkg::t_out_item     o_item
);
    localparam int CW = $clog2(MAX_FRAME_PIXELS + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_FRAME_PIXELS);
    dpag_pkg::t_state r_st, n_st;
    logic [CW-1:0] r_vc, r_ov;
    logic [56:0]   r_ss;
    logic [31:0]   r_scale;
    logic          r_ovalid;
    dpag_pkg::t_out_item r_out;
    // divider: dividend n*2^56 (CW+56 bits), divisor 25*ss (62 bits)
    logic [63:0]   r_rem, r_den;
    logic [CW+55:0] r_num;
    logic [6:0]    r_cyc;
    logic [63:0]   r_q;
    // square root
    logic [63:0]   r_sv, r_res, r_b;
    logic [24:0]   r_ovsnap;
    logic          slot_free, fire, load_out;
    logic [31:0]   sq;
    logic [57:0]   sum;
    logic [47:0]   prod;
    logic [8:0]    gval;
    logic [63:0]   rsh;
    logic [63:0]   sub;
    logic [63:0]   rb;
    assign slot_free = !r_ovalid || i_pop;
    assign fire = r_st == dpag_pkg::ST_RUN && i_has && slot_free;
    assign load_out = (fire && (i_work.is_map ||
                                (i_work.last && i_manual_scale != 32'd0))) ||
                      (r_st == dpag_pkg::ST_OUT && slot_free);
    assign o_take = fire;
    assign o_empty = !r_ovalid;
    assign o_item = r_out;
    always_comb begin
        n_st = r_st;
        case (r_st)
            dpag_pkg::ST_RUN:
                if (fire && !i_work.is_map && i_work.last && i_manual_scale == 32'd0)
                    n_st = dpag_pkg::ST_DIV;
            dpag_pkg::ST_DIV:  if (r_cyc == 7'd0) n_st = dpag_pkg::ST_SQRT;
            dpag_pkg::ST_SQRT: if (r_b == 64'd0) n_st = dpag_pkg::ST_OUT;
            dpag_pkg::ST_OUT:  if (slot_free) n_st = dpag_pkg::ST_RUN;
            default: n_st = dpag_pkg::ST_RUN;
        endcase
    end
    always_comb begin
        sq = 32'(i_work.px) * 32'(i_work.px);
        sum = {1'b0, r_ss} + 58'(sq);
        prod = 48'(r_scale) * 48'(i_work.px);
        if (prod < 48'h100000) gval = 9'd1;
        else if (prod > 48'd267386880) gval = 9'd255;
        else if (i_negate) gval = 9'(prod[47:20]) + 9'(prod[19:0] != '0);
        else gval = 9'(prod[47:20]);
        rsh = {r_rem[62:0], r_num[CW+55]};
        sub = r_res + r_b;
        rb = r_b;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= dpag_pkg::ST_RUN;
            r_vc <= '0; r_ov <= '0; r_ss <= '0;
            r_scale <= dpag_pkg::SCALE_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (load_out) r_ovalid <= 1'b1;
            else if (i_pop && r_ovalid) r_ovalid <= 1'b0;
            case (r_st)
                dpag_pkg::ST_RUN: if (fire) begin
                    if (i_work.is_map) begin
                        r_out.kind <= dpag_pkg::KIND_MAP;
                        r_out.overload_count <= '0;
                        r_out.scale_used <= '0;
                        if (!i_work.in_bounds) r_out.gray <= i_negate ? 8'd254 : 8'd1;
                        else if (i_work.is_over) r_out.gray <= i_negate ? 8'd255 : 8'd0;
                        else r_out.gray <= i_negate ? 8'(9'd255 - gval) : gval[7:0];
                    end else begin
                        logic [CW-1:0] vc, ov;
                        logic [56:0] ss;
                        vc = r_vc; ov = r_ov; ss = r_ss;
                        if (i_work.is_over && ov < CMAX) ov = ov + 1'b1;
                        if (i_work.is_valid) begin
                            if (vc < CMAX) vc = vc + 1'b1;
                            ss = sum[57] ? dpag_pkg::SUMSQ_MAX : sum[56:0];
                        end
                        if (i_work.last) begin
                            r_vc <= '0; r_ov <= '0; r_ss <= '0;
                            r_ovsnap <= 25'(ov);
                            if (i_manual_scale != 32'd0) begin
                                r_scale <= i_manual_scale;
                                r_out.kind <= dpag_pkg::KIND_SUM;
                                r_out.gray <= '0;
                                r_out.overload_count <= 25'(ov);
                                r_out.scale_used <= i_manual_scale;
                            end else begin
                                if (vc == '0 || ss == '0) begin
                                    r_num <= {(CW)'(1), 56'd0};
                                    r_den <= 64'd25;
                                end else begin
                                    r_num <= {vc, 56'd0};
                                    r_den <= 64'(ss) * 64'd25;
                                end
                                r_rem <= '0; r_q <= '0;
                                r_cyc <= 7'(CW + 55);
                            end
                        end else begin
                            r_vc <= vc; r_ov <= ov; r_ss <= ss;
                        end
                    end
                end
                dpag_pkg::ST_DIV: begin
                    r_num <= r_num << 1;
                    r_cyc <= r_cyc - 1'b1;
                    if (rsh >= r_den) begin
                        r_rem <= rsh - r_den; r_q <= {r_q[62:0], 1'b1};
                    end else begin
                        r_rem <= rsh; r_q <= {r_q[62:0], 1'b0};
                    end
                    if (r_cyc == 7'd0) begin
                        r_res <= '0; r_b <= 64'h4000_0000_0000_0000;
                        r_sv <= (rsh >= r_den) ? {r_q[62:0], 1'b1} : {r_q[62:0], 1'b0};
                    end
                end
                dpag_pkg::ST_SQRT: if (rb != 0) begin
                    if (r_sv >= sub) begin
                        r_sv <= r_sv - sub; r_res <= (r_res >> 1) + rb;
                    end else r_res <= r_res >> 1;
                    r_b <= rb >> 2;
                end
                dpag_pkg::ST_OUT: if (slot_free) begin
                    r_scale <= r_res[31:0];
                    r_out.kind <= dpag_pkg::KIND_SUM;
                    r_out.gray <= '0;
                    r_out.overload_count <= r_ovsnap;
                    r_out.scale_used <= r_res[31:0];
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/detector_pixel_autoscale_to_gray.sv
// Detector pixel autoscale to gray.
// Input queue: push a request (operation, pixel, in_bounds, last) while full
// is low. Result register: the result is shown while empty is low; pop
// takes it. Configuration over an APB-style port: manual scale at 0x0,
// negate at 0x4, byte swap at 0x8; pready is always high.
// Requests are byte-swapped if enabled and classified on entry, then held
// in a four-deep queue ahead of the execution stage.
// Map and statistics requests: one per cycle while the result register is
// free or being popped. A request is written into the front queue and then
// taken by the execution stage, which registers a map result as it takes it.
// Frame end with autoscale: a bit-serial divider, a radix-4 square root and
// an output state follow in turn; the execution stage holds further
// requests meanwhile while the front queue keeps accepting until full.
// When the receiver stalls, the result register holds and the execution
// stage waits; the front queue absorbs up to four requests.
// Reset (synchronous, active low) clears the statistics, the queues and the
// registers, and sets the scale to the autoscale value for sigma one.
`default_nettype none
module detector_pixel_autoscale_to_gray #(
    parameter int MAX_FRAME_PIXELS = 16777216
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire dpag_pkg::t_in_item  i_item,
    output logic                     o_empty,
    input  wire logic                i_pop,
    output dpag_pkg::t_out_item      o_item,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);
    logic [31:0] r_manual_scale;
    logic        r_negate, r_swap;
    logic        has, take;
    dpag_pkg::t_work work;

    assign pready = 1'b1;
    // register writes complete on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual_scale <= '0; r_negate <= 1'b0; r_swap <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                dpag_pkg::ADDR_SCALE:  r_manual_scale <= pwdata;
                dpag_pkg::ADDR_NEGATE: r_negate <= pwdata[0];
                dpag_pkg::ADDR_SWAP:   r_swap <= pwdata[0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            dpag_pkg::ADDR_SCALE:  prdata = r_manual_scale;
            dpag_pkg::ADDR_NEGATE: prdata = {31'd0, r_negate};
            dpag_pkg::ADDR_SWAP:   prdata = {31'd0, r_swap};
            default:               prdata = '0;
        endcase
    end

    dpag_front #(.DEPTH(4)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_swap(r_swap),
        .i_push(i_push), .i_item(i_item), .o_full(o_full),
        .i_take(take), .o_has(has), .o_work(work)
    );
    dpag_back #(.MAX_FRAME_PIXELS(MAX_FRAME_PIXELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_manual_scale(r_manual_scale),
        .i_negate(r_negate), .i_has(has), .i_work(work), .o_take(take),
        .o_empty(o_empty), .i_pop(i_pop), .o_item(o_item)
    );
endmodule
`default_nettype wire
